/* src/ffra_pkg.sv */
`timescale 1ns / 1ps
// ffra_pkg: sizes, state codes and shared types of the first-fit interval allocator
// used by the channel interfaces, the register cells, the group encoder and the top level

package ffra_pkg;

  localparam int NUM_REGS   = 256;
  localparam int POS_BITS   = 20;

  // fixed result field widths
  localparam int REG_NUM_W  = 8;
  localparam int PRESS_W    = 9;

  // cells are grouped for the two-level first-fit search
  localparam int GRP_SZ     = 16;
  localparam int LOC_W      = $clog2(GRP_SZ);
  localparam int NUM_GRPS   = (NUM_REGS + GRP_SZ - 1) / GRP_SZ;
  localparam int GRP_W      = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
  localparam int PAD_REGS   = NUM_GRPS * GRP_SZ;
  localparam int CH_W       = GRP_W + LOC_W;
  localparam int CH_EXT_W   = CH_W + REG_NUM_W;

  // register usage counter holds 0..NUM_REGS
  localparam int CNT_W      = $clog2(NUM_REGS + 1);
  localparam int CNT_EXT_W  = CNT_W + PRESS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_WR
  } ffra_state_t;

  // per-group outcome of the first-fit search
  typedef struct packed {
    logic             any;
    logic [LOC_W-1:0] loc;
    logic             free;
  } grp_res_t;

endpackage

/* src/ffra_if.sv */
`timescale 1ns / 1ps
// ffra_in_if / ffra_out_if: valid-ready channels of the interval allocator
// depends on ffra_pkg for field widths

interface ffra_in_if;
  logic                          valid;
  logic                          ready;
  logic [ffra_pkg::POS_BITS-1:0] def_position;
  logic [ffra_pkg::POS_BITS-1:0] last_use_position;
  logic                          last_in_program;

  modport source (output valid, def_position, last_use_position, last_in_program,
                  input ready);
  modport sink   (input valid, def_position, last_use_position, last_in_program,
                  output ready);
endinterface

interface ffra_out_if;
  logic                           valid;
  logic                           ready;
  logic [ffra_pkg::REG_NUM_W-1:0] register_number;
  logic                           alloc_failed;
  logic [ffra_pkg::PRESS_W-1:0]   pressure;
  logic [ffra_pkg::PRESS_W-1:0]   peak_pressure;

  modport source (output valid, register_number, alloc_failed, pressure, peak_pressure,
                  input ready);
  modport sink   (input valid, register_number, alloc_failed, pressure, peak_pressure,
                  output ready);
endinterface

/* src/ffra_cell.sv */
`timescale 1ns / 1ps
// ffra_cell: one physical register entry (last use, in-use flag) with its fit test
// depends on ffra_pkg; chained to its neighbor through the hit signal

module ffra_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ffra_pkg::POS_BITS-1:0] def_pos,
  input  logic                          wr_en,
  input  logic [ffra_pkg::POS_BITS-1:0] wr_last,
  input  logic                          clr,
  input  logic                          hit_in,
  output logic                          hit_out,
  output logic                          first,
  output logic                          free
);
  import ffra_pkg::*;

  logic [POS_BITS-1:0] last_use_r, last_use_nxt;
  logic                in_use_r, in_use_nxt;
  logic                fit_r, fit_nxt;
  logic                free_r, free_nxt;

  always_comb begin
    last_use_nxt = wr_en ? wr_last : last_use_r;
    if (clr) begin
      in_use_nxt = 1'b0;
    end else if (wr_en) begin
      in_use_nxt = 1'b1;
    end else begin
      in_use_nxt = in_use_r;
    end
    fit_nxt  = !in_use_r || (last_use_r < def_pos);
    free_nxt = !in_use_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      fit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      in_use_r <= in_use_nxt;
      fit_r    <= fit_nxt;
      free_r   <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_use_r <= last_use_nxt;
  end

  // first fitting cell in the group: no earlier neighbor has claimed a hit
  assign first   = fit_r && !hit_in;
  assign hit_out = fit_r || hit_in;
  assign free    = free_r;

endmodule

/* src/ffra_grp_enc.sv */
`timescale 1ns / 1ps
// ffra_grp_enc: registers the one-hot first fit of a group of cells as an index
// depends on ffra_pkg for group size and the grp_res_t struct

module ffra_grp_enc (
  input  logic                        clk,
  input  logic [ffra_pkg::GRP_SZ-1:0] first,
  input  logic [ffra_pkg::GRP_SZ-1:0] free,
  input  logic                        hit_last,
  output ffra_pkg::grp_res_t          res_r
);
  import ffra_pkg::*;

  grp_res_t res_nxt;

  always_comb begin
    res_nxt.any  = hit_last;
    res_nxt.loc  = '0;
    res_nxt.free = 1'b0;
    for (int k = 0; k < GRP_SZ; k++) begin
      if (first[k]) begin
        res_nxt.loc  = res_nxt.loc | LOC_W'(k);
        res_nxt.free = res_nxt.free | free[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

/* src/first_fit_interval_register_allocator_top.sv */
`timescale 1ns / 1ps
// first_fit_interval_register_allocator_top: row of register cells with a grouped first-fit search
// depends on ffra_pkg, ffra_in_if / ffra_out_if, ffra_cell and ffra_grp_enc
//
// channel  | dir | handshake         | payload
// in_ch    | in  | valid/ready       | def_position, last_use_position, last_in_program
// out_ch   | out | valid/ready       | register_number, alloc_failed, pressure, peak_pressure
//
// each interval steps through accept, cell compare, group encode, pick + write back before the next is taken
// the interval is taken only in idle; the write back waits while the output register is full and not read
// the result sits in an output register, so the next interval is accepted while it waits
// rst_n is synchronous; it frees every cell and clears the usage and peak counters at once
// a last-in-program interval frees all cells in the same cycle its own write lands

module first_fit_interval_register_allocator_top (
  input  logic       clk,
  input  logic       rst_n,
  ffra_in_if.sink    in_ch,
  ffra_out_if.source out_ch
);
  import ffra_pkg::*;

  // control
  ffra_state_t state_r, state_nxt;
  logic        commit;

  // latched transaction
  logic [POS_BITS-1:0] def_r, def_nxt;
  logic [POS_BITS-1:0] last_r, last_nxt;
  logic                fin_r, fin_nxt;

  // counters
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [REG_NUM_W-1:0] out_reg_r, out_reg_nxt;
  logic                 out_fail_r, out_fail_nxt;
  logic [PRESS_W-1:0]   out_press_r, out_press_nxt;
  logic [PRESS_W-1:0]   out_peak_r, out_peak_nxt;

  // cell row
  logic [PAD_REGS-1:0] hit_in_v, hit_out_v, first_v, free_v;
  grp_res_t            grp_r [NUM_GRPS];

  // group pick
  logic             found;
  logic [GRP_W-1:0] sel;
  logic [CH_W-1:0]  chosen;
  logic             chosen_free;
  logic [CH_EXT_W-1:0]  chosen_ext;
  logic [CNT_EXT_W-1:0] used_ext, peak_ext;

  // ---------------------------------------------------------------------------
  // cells, grouped; the hit chain restarts at each group boundary
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_GRPS; g++) begin : g_grp
    for (genvar k = 0; k < GRP_SZ; k++) begin : g_slot
      localparam int I = g * GRP_SZ + k;
      if (k == 0) begin : g_head
        assign hit_in_v[I] = 1'b0;
      end else begin : g_link
        assign hit_in_v[I] = hit_out_v[I-1];
      end
      if (I < NUM_REGS) begin : g_cell
        ffra_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .def_pos (def_r),
          .wr_en   (commit && found && (chosen == CH_W'(I))),
          .wr_last (last_r),
          .clr     (commit && fin_r),
          .hit_in  (hit_in_v[I]),
          .hit_out (hit_out_v[I]),
          .first   (first_v[I]),
          .free    (free_v[I])
        );
      end else begin : g_pad
        // padding slot past the last register never fits
        assign hit_out_v[I] = hit_in_v[I];
        assign first_v[I]   = 1'b0;
        assign free_v[I]    = 1'b0;
      end
    end

    ffra_grp_enc u_enc (
      .clk      (clk),
      .first    (first_v[g*GRP_SZ +: GRP_SZ]),
      .free     (free_v[g*GRP_SZ +: GRP_SZ]),
      .hit_last (hit_out_v[g*GRP_SZ + GRP_SZ - 1]),
      .res_r    (grp_r[g])
    );
  end

  // ---------------------------------------------------------------------------
  // lowest group with a fit wins
  // ---------------------------------------------------------------------------
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int g = 0; g < NUM_GRPS; g++) begin
      if (!found && grp_r[g].any) begin
        found = 1'b1;
        sel   = GRP_W'(g);
      end
    end
  end

  assign chosen      = {sel, grp_r[sel].loc};
  assign chosen_free = grp_r[sel].free;

  // ---------------------------------------------------------------------------
  // state machine: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = in_ch.valid ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_ENC;
      S_ENC:   state_nxt = S_WR;
      S_WR:    state_nxt = commit ? S_IDLE : S_WR;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        commit      = 1'b0;
      end
      S_WR: begin
        in_ch.ready = 1'b0;
        commit      = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
        commit      = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    def_nxt  = def_r;
    last_nxt = last_r;
    fin_nxt  = fin_r;
    if (in_ch.valid && in_ch.ready) begin
      def_nxt  = in_ch.def_position;
      last_nxt = in_ch.last_use_position;
      fin_nxt  = in_ch.last_in_program;
    end
  end

  always_comb begin
    // a fresh register bumps the usage count; reusing an expired one does not
    used_nxt = used_r + CNT_W'(found && chosen_free);
    peak_nxt = (used_nxt > peak_r) ? used_nxt : peak_r;
    used_ext   = CNT_EXT_W'(used_nxt);
    peak_ext   = CNT_EXT_W'(peak_nxt);
    chosen_ext = CH_EXT_W'(chosen);
  end

  always_comb begin
    out_reg_nxt   = out_reg_r;
    out_fail_nxt  = out_fail_r;
    out_press_nxt = out_press_r;
    out_peak_nxt  = out_peak_r;
    if (commit) begin
      out_reg_nxt   = found ? chosen_ext[REG_NUM_W-1:0] : '0;
      out_fail_nxt  = !found;
      out_press_nxt = used_ext[PRESS_W-1:0];
      out_peak_nxt  = peak_ext[PRESS_W-1:0];
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        // end of program: usage restarts, peak is kept
        used_r <= fin_r ? '0 : used_nxt;
        peak_r <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    def_r       <= def_nxt;
    last_r      <= last_nxt;
    fin_r       <= fin_nxt;
    out_reg_r   <= out_reg_nxt;
    out_fail_r  <= out_fail_nxt;
    out_press_r <= out_press_nxt;
    out_peak_r  <= out_peak_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.register_number = out_reg_r;
  assign out_ch.alloc_failed    = out_fail_r;
  assign out_ch.pressure        = out_press_r;
  assign out_ch.peak_pressure   = out_peak_r;

endmodule
